### rtl/betal_pkg.sv
// Shared types, widths and helpers for the battery time estimate block.
// No dependencies; imported by battery_eta_gate_and_lock.
package betal_pkg;

	// Fixed-point fraction bits of the hour estimates.
	localparam int FRAC_BITS = 10;

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int PCT_W   = 7;
	localparam int MWH_W   = 20;
	localparam int RATE_W  = 19;
	localparam int HOURS_W = 15;
	localparam int LO_W    = 10;
	localparam int GATE_W  = 16;
	localparam int MINR_W  = 16;
	localparam int END_W   = TIME_W + 1;

	// Division datapath widths.
	localparam int SCALE_W = 8;                       // 100 + pct - taper stays below 256
	localparam int PROD_W  = MWH_W + SCALE_W;
	localparam int NUM_W   = PROD_W + FRAC_BITS;
	localparam int DEN_W   = RATE_W + 7;              // rate times 100
	localparam int CNT_W   = $clog2(NUM_W);

	localparam int PCT_SCALE = 100;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = ((TIME_W + PCT_W + 2 * MWH_W + 2 * RATE_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = ((2 * HOURS_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Input word bit offsets.
	localparam int OFS_NOW     = 0;
	localparam int OFS_PCT     = OFS_NOW + TIME_W;
	localparam int OFS_STORED  = OFS_PCT + PCT_W;
	localparam int OFS_CAP     = OFS_STORED + MWH_W;
	localparam int OFS_CHOSEN  = OFS_CAP + MWH_W;
	localparam int OFS_GAUGE   = OFS_CHOSEN + RATE_W;
	localparam int IN_USED_W   = OFS_GAUGE + RATE_W;

	// Power mode of one sample.
	typedef enum logic [1:0] {
		MODE_DIS = 2'd0,
		MODE_CHG = 2'd1,
		MODE_NEU = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_MS   = 3'd0,
		CFG_MIN_RATE  = 3'd1,
		CFG_TAPER     = 3'd2,
		CFG_FULL_PCT  = 3'd3,
		CFG_MIN_HOURS = 3'd4,
		CFG_MAX_FULL  = 3'd5,
		CFG_MAX_LEFT  = 3'd6
	} cfg_idx_t;

	// Magnitude of a two's complement rate; the most negative code maps to 2^(RATE_W-1).
	function automatic logic [RATE_W-1:0] abs_rate(input logic [RATE_W-1:0] v);
		abs_rate = v[RATE_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

### rtl/battery_eta_gate_and_lock.sv
// Battery time-to-full and time-remaining estimator with mode gate and percent lock.
// Depends on betal_pkg for widths, the mode and register index types and abs_rate.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample fields, tuser: charging, on_ac
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: estimates, tuser: wait bits, mode
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A word that needs a quotient passes through capture, setup, 38 steps of the
// shared restoring divider (one quotient bit per cycle), clamp and finish; a word
// with no estimate goes from setup straight to clamp. The divider width sets the step count.
// Reset clears the configuration to its defaults and the gate and lock state.
// A result waits in the output register; the block takes the next word once the result
// has been passed to that register, and a stalled output holds the finish step.
module battery_eta_gate_and_lock (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// tdata from bit 0: now_ms[31:0], charge_pct[38:32], stored_mwh[58:39],
	// capacity_mwh[78:59], chosen_rate_mw[97:79], gauge_rate_mw[116:98], zero fill
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [betal_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// tuser from bit 0: charging, on_ac
	input  logic [betal_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	// tdata from bit 0: to_full_q10[14:0], left_q10[29:15], zero fill
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [betal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// tuser from bit 0: to_full_wait, left_wait, mode_now[3:2]
	output logic [betal_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [betal_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [betal_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import betal_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_CLAMP,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [GATE_W-1:0]  gate_ms_q;
	logic [MINR_W-1:0]  min_rate_q;
	logic [PCT_W-1:0]   taper_q;
	logic [PCT_W-1:0]   full_pct_q;
	logic [LO_W-1:0]    min_hours_q;
	logic [HOURS_W-1:0] max_full_q;
	logic [HOURS_W-1:0] max_left_q;

	// Gate and lock state.
	logic               last_valid_q;
	logic [PCT_W-1:0]   last_seen_q;
	mode_t              stable_q;
	logic [HOURS_W-1:0] lock_full_q;
	logic [HOURS_W-1:0] lock_left_q;
	logic               gate_on_q;
	logic [END_W-1:0]   gate_end_q;

	// Captured sample.
	logic [TIME_W-1:0]        now_q;
	logic                     chg_q;
	logic                     ac_q;
	logic [PCT_W-1:0]         pct_q;
	logic [MWH_W-1:0]         stored_q;
	logic [MWH_W-1:0]         cap_q;
	logic signed [RATE_W-1:0] chosen_q;
	logic signed [RATE_W-1:0] gauge_q;

	// Divider and estimate registers.
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [HOURS_W-1:0] hi_q;
	logic               num_zero_q;
	logic               den_zero_q;
	logic               computed_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [HOURS_W-1:0] est_q;

	// Output register.
	logic               m_valid_q;
	logic [HOURS_W-1:0] out_full_q;
	logic [HOURS_W-1:0] out_left_q;
	logic               out_fw_q;
	logic               out_lw_q;
	mode_t              out_mode_q;

	logic in_accept;
	logic out_free;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * HOURS_W){1'b0}}, out_left_q, out_full_q};
	assign m_axis_tuser  = {out_mode_q, out_lw_q, out_fw_q};

	// Setup: pick the rate, decide whether an estimate is made, form numerator and divisor.
	logic [RATE_W-1:0]  su_sel;
	logic [RATE_W-1:0]  su_rate;
	logic               su_en;
	logic [MWH_W-1:0]   su_missing;
	logic [SCALE_W-1:0] su_scale;
	logic [PROD_W-1:0]  su_prod;
	logic [NUM_W-1:0]   su_num;
	logic [DEN_W-1:0]   su_den;

	always_comb begin
		su_sel  = abs_rate(chosen_q);
		su_rate = (su_sel > RATE_W'(1)) ? su_sel : abs_rate(gauge_q);
		su_en   = ({{(RATE_W - MINR_W){1'b0}}, min_rate_q} <= su_rate) &&
			(chg_q || (stored_q != '0));
		su_missing = (cap_q > stored_q) ? (cap_q - stored_q) : '0;
		if (pct_q > taper_q) begin
			su_scale = SCALE_W'(PCT_SCALE) + SCALE_W'(pct_q) - SCALE_W'(taper_q);
		end else begin
			su_scale = SCALE_W'(PCT_SCALE);
		end
		su_prod = PROD_W'(su_missing) * PROD_W'(su_scale);
		if (chg_q) begin
			su_num = {su_prod, {FRAC_BITS{1'b0}}};
			su_den = DEN_W'(su_rate) * DEN_W'(PCT_SCALE);
		end else begin
			su_num = NUM_W'({stored_q, {FRAC_BITS{1'b0}}});
			su_den = DEN_W'(su_rate);
		end
	end

	// One restoring division step: bring down the next numerator bit and try the divisor.
	logic [DEN_W:0] dv_trial;
	logic [DEN_W:0] dv_diff;
	logic           dv_fit;

	always_comb begin
		dv_trial = {rem_q, num_q[NUM_W-1]};
		dv_diff  = dv_trial - {1'b0, den_q};
		dv_fit   = (dv_trial >= {1'b0, den_q});
	end

	// Clamp: special cases, then raise to the minimum and lower to the ceiling.
	logic [NUM_W-1:0]   cl_quot;
	logic [NUM_W-1:0]   cl_raised;
	logic [HOURS_W-1:0] cl_est;

	always_comb begin
		if (num_zero_q) begin
			cl_quot = '0;
		end else if (den_zero_q) begin
			cl_quot = NUM_W'(hi_q);
		end else begin
			cl_quot = num_q;
		end
		cl_raised = (cl_quot < NUM_W'(min_hours_q)) ? NUM_W'(min_hours_q) : cl_quot;
		cl_est    = (cl_raised > NUM_W'(hi_q)) ? hi_q : cl_raised[HOURS_W-1:0];
	end

	// Finish: mode decision, gate and lock update, result fields.
	mode_t              fn_mode;
	logic               fn_is_full;
	logic [HOURS_W-1:0] fn_full;
	logic [HOURS_W-1:0] fn_left;
	logic               fn_fw;
	logic               fn_lw;
	logic               fn_gate_on;
	logic [END_W-1:0]   fn_gate_end;
	logic               fn_valid;
	logic [PCT_W-1:0]   fn_seen;
	mode_t              fn_stable;
	logic [HOURS_W-1:0] fn_lock_full;
	logic [HOURS_W-1:0] fn_lock_left;
	logic               fn_hold;
	logic               fn_new_pct;

	always_comb begin
		fn_is_full = ac_q && (pct_q >= full_pct_q);
		if (chg_q && !fn_is_full) begin
			fn_mode = MODE_CHG;
		end else if (!ac_q && !chg_q) begin
			fn_mode = MODE_DIS;
		end else begin
			fn_mode = MODE_NEU;
		end
		fn_full      = (computed_q && chg_q) ? est_q : '0;
		fn_left      = (computed_q && !chg_q) ? est_q : '0;
		fn_fw        = 1'b0;
		fn_lw        = 1'b0;
		fn_gate_on   = gate_on_q;
		fn_gate_end  = gate_end_q;
		fn_valid     = last_valid_q;
		fn_seen      = last_seen_q;
		fn_stable    = stable_q;
		fn_lock_full = lock_full_q;
		fn_lock_left = lock_left_q;
		fn_hold      = 1'b0;
		fn_new_pct   = !last_valid_q || (pct_q != last_seen_q);

		if (!gate_on_q && fn_mode != MODE_NEU && fn_mode != stable_q) begin
			// Entering a new active mode starts the gate.
			fn_gate_on  = 1'b1;
			fn_gate_end = END_W'(now_q) + END_W'(gate_ms_q);
			fn_valid    = 1'b0;
			fn_stable   = fn_mode;
			if (fn_mode == MODE_CHG) begin
				fn_full = '0;
				fn_fw   = 1'b1;
			end else begin
				fn_left = '0;
				fn_lw   = 1'b1;
			end
		end else begin
			if (fn_mode == MODE_NEU) begin
				fn_gate_on  = 1'b0;
				fn_gate_end = '0;
				fn_stable   = MODE_NEU;
			end
			// A running gate reports calculating until its end time.
			if (fn_gate_on) begin
				if ({1'b0, now_q} < gate_end_q) begin
					fn_hold = 1'b1;
					if (fn_mode == MODE_CHG) begin
						fn_full = '0;
						fn_fw   = 1'b1;
					end
					if (fn_mode == MODE_DIS) begin
						fn_left = '0;
						fn_lw   = 1'b1;
					end
				end else begin
					fn_gate_on  = 1'b0;
					fn_gate_end = '0;
				end
			end
			// Locked values refresh only when the percent changes.
			if (!fn_hold) begin
				if (fn_mode == MODE_CHG) begin
					if (fn_new_pct) begin
						if (computed_q && fn_full != '0) begin
							fn_lock_full = fn_full;
						end
						fn_seen  = pct_q;
						fn_valid = 1'b1;
					end
					fn_full = fn_lock_full;
				end else if (fn_mode == MODE_DIS) begin
					if (fn_new_pct) begin
						if (computed_q && fn_left != '0) begin
							fn_lock_left = fn_left;
						end
						fn_seen  = pct_q;
						fn_valid = 1'b1;
					end
					fn_left = fn_lock_left;
				end else begin
					fn_seen  = pct_q;
					fn_valid = 1'b1;
				end
			end
		end
	end

	// Sequencer, configuration, gate and lock state, and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gate_ms_q    <= GATE_W'(5000);
			min_rate_q   <= MINR_W'(100);
			taper_q      <= PCT_W'(80);
			full_pct_q   <= PCT_W'(99);
			min_hours_q  <= LO_W'(51);
			max_full_q   <= HOURS_W'(10240);
			max_left_q   <= HOURS_W'(24576);
			last_valid_q <= 1'b0;
			last_seen_q  <= '0;
			stable_q     <= MODE_NEU;
			lock_full_q  <= '0;
			lock_left_q  <= '0;
			gate_on_q    <= 1'b0;
			gate_end_q   <= '0;
			m_valid_q    <= 1'b0;
			out_full_q   <= '0;
			out_left_q   <= '0;
			out_fw_q     <= 1'b0;
			out_lw_q     <= 1'b0;
			out_mode_q   <= MODE_NEU;
		end else begin
			// Configuration writes.
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GATE_MS:   gate_ms_q   <= cfg_data[GATE_W-1:0];
					CFG_MIN_RATE:  min_rate_q  <= cfg_data[MINR_W-1:0];
					CFG_TAPER:     taper_q     <= cfg_data[PCT_W-1:0];
					CFG_FULL_PCT:  full_pct_q  <= cfg_data[PCT_W-1:0];
					CFG_MIN_HOURS: min_hours_q <= cfg_data[LO_W-1:0];
					CFG_MAX_FULL:  max_full_q  <= cfg_data[HOURS_W-1:0];
					CFG_MAX_LEFT:  max_left_q  <= cfg_data[HOURS_W-1:0];
					default: ;
				endcase
			end

			// The output register refills from the finish step, else empties on a handshake.
			if (state_q == ST_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (su_en && su_num != '0 && su_den != '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_CLAMP;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q      <= ST_IDLE;
						last_valid_q <= fn_valid;
						last_seen_q  <= fn_seen;
						stable_q     <= fn_stable;
						lock_full_q  <= fn_lock_full;
						lock_left_q  <= fn_lock_left;
						gate_on_q    <= fn_gate_on;
						gate_end_q   <= fn_gate_end;
						out_full_q   <= fn_full;
						out_left_q   <= fn_left;
						out_fw_q     <= fn_fw;
						out_lw_q     <= fn_lw;
						out_mode_q   <= fn_mode;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample capture and the shared divider datapath.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q    <= s_axis_tdata[OFS_NOW +: TIME_W];
			pct_q    <= s_axis_tdata[OFS_PCT +: PCT_W];
			stored_q <= s_axis_tdata[OFS_STORED +: MWH_W];
			cap_q    <= s_axis_tdata[OFS_CAP +: MWH_W];
			chosen_q <= s_axis_tdata[OFS_CHOSEN +: RATE_W];
			gauge_q  <= s_axis_tdata[OFS_GAUGE +: RATE_W];
			chg_q    <= s_axis_tuser[0];
			ac_q     <= s_axis_tuser[1];
		end
		if (state_q == ST_SETUP) begin
			num_q      <= su_num;
			den_q      <= su_den;
			rem_q      <= '0;
			hi_q       <= chg_q ? max_full_q : max_left_q;
			num_zero_q <= (su_num == '0);
			den_zero_q <= (su_den == '0);
			computed_q <= su_en;
			cnt_q      <= CNT_W'(NUM_W - 1);
		end
		// The numerator register turns into the quotient as the bits shift through.
		if (state_q == ST_DIV) begin
			rem_q <= dv_fit ? dv_diff[DEN_W-1:0] : dv_trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], dv_fit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == ST_CLAMP) begin
			est_q <= cl_est;
		end
	end

`ifndef ASSERT_OFF
	// A result appears only out of the finish step.
	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	// The gate end time is cleared whenever the gate is off.
	a_gate_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!gate_on_q |-> (gate_end_q == '0))
		else $error("gate end time left set with the gate off");

	// A running gate always belongs to an active mode.
	a_gate_mode: assert property (@(posedge clk) disable iff (!arst_n)
		gate_on_q |-> (stable_q != MODE_NEU))
		else $error("gate running in neutral mode");

	// After a word is taken the block stays busy while it works.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken again before the word was finished");
`endif

endmodule

### dv/eta_result_checker.sv
// Checker for battery_eta_gate_and_lock. It follows the configuration and sample words,
// predicts each result word and compares it with the word that the block returns.
// Depends on betal_pkg for field widths, word offsets, modes and register indexes.
module eta_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// now_ms, charge_pct, stored, capacity, rates
	input  logic [betal_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [betal_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // charging, on_ac
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [betal_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // to_full_q10, left_q10
	// to_full_wait, left_wait, mode_now
	input  logic [betal_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [betal_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [betal_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                mismatches,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import betal_pkg::*;

	typedef struct packed {
		logic [HOURS_W-1:0] to_full;
		logic               full_wait;
		logic [HOURS_W-1:0] left;
		logic               left_wait;
		mode_t              mode;
	} estimate_t;

	// Configuration as seen through the register channel.
	logic [GATE_W-1:0]  gate_ms_r;
	logic [MINR_W-1:0]  min_rate_r;
	logic [PCT_W-1:0]   taper_r;
	logic [PCT_W-1:0]   full_pct_r;
	logic [LO_W-1:0]    min_hours_r;
	logic [HOURS_W-1:0] max_full_r;
	logic [HOURS_W-1:0] max_left_r;

	// Gate and lock state of the estimator.
	logic               pct_seen_valid;
	logic [PCT_W-1:0]   pct_seen;
	mode_t              settled_mode;
	logic [HOURS_W-1:0] held_full;
	logic [HOURS_W-1:0] held_left;
	logic               gate_running;
	logic [END_W-1:0]   gate_deadline;

	estimate_t estimate_q[$];
	estimate_t seen_word;
	estimate_t want_word;
	estimate_t fresh_word;
	int        fail_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("%0t ns: %s read %0d, predicted %0d", $time, field, got, want);
	endtask

	// Magnitude of a signed rate; the most negative code gives 2^(RATE_W-1).
	function automatic logic [RATE_W:0] rate_magnitude(input logic [RATE_W-1:0] v);
		if (v[RATE_W-1]) begin
			return {1'b0, ~v} + 1'b1;
		end
		return {1'b0, v};
	endfunction

	// Quotient raised to the lower clamp, then lowered to the upper one.
	function automatic logic [HOURS_W-1:0] clamp_hours(input logic [63:0] num,
		input logic [63:0] den, input logic [LO_W-1:0] lo, input logic [HOURS_W-1:0] hi);
		logic [63:0] q;
		if (num == 0) begin
			q = 0;
		end else if (den == 0) begin
			q = 64'(hi);
		end else begin
			q = num / den;
		end
		if (q < 64'(lo)) begin
			q = 64'(lo);
		end
		if (q > 64'(hi)) begin
			q = 64'(hi);
		end
		return q[HOURS_W-1:0];
	endfunction

	// Works out the result word of one sample and advances the gate and lock state.
	task automatic predict_estimate(input logic [TIME_W-1:0] now, input logic chg,
		input logic ac, input logic [PCT_W-1:0] pct, input logic [MWH_W-1:0] stored,
		input logic [MWH_W-1:0] cap, input logic [RATE_W-1:0] chosen,
		input logic [RATE_W-1:0] gauge, output estimate_t est);
		logic [RATE_W:0] sel;
		logic [RATE_W:0] rate;
		logic [63:0]     missing;
		logic [63:0]     scale;
		logic [63:0]     num;
		logic [63:0]     den;
		logic            computed;
		logic            is_full;
		logic            held;
		mode_t           md;

		est = '0;
		computed = 1'b0;
		held = 1'b0;
		sel = rate_magnitude(chosen);
		rate = (sel > 1) ? sel : rate_magnitude(gauge);

		// Raw estimates, only at or above the least usable rate.
		if (rate >= {4'd0, min_rate_r}) begin
			if (chg) begin
				missing = (cap > stored) ? 64'(cap) - 64'(stored) : 64'd0;
				scale = (pct > taper_r) ? 64'(PCT_SCALE + pct - taper_r) : 64'(PCT_SCALE);
				num = (missing << FRAC_BITS) * scale;
				den = 64'(rate) * PCT_SCALE;
				est.to_full = clamp_hours(num, den, min_hours_r, max_full_r);
				computed = 1'b1;
			end else if (stored != 0) begin
				num = 64'(stored) << FRAC_BITS;
				den = 64'(rate);
				est.left = clamp_hours(num, den, min_hours_r, max_left_r);
				computed = 1'b1;
			end
		end

		is_full = ac && (pct >= full_pct_r);
		if (chg && !is_full) begin
			md = MODE_CHG;
		end else if (!ac && !chg) begin
			md = MODE_DIS;
		end else begin
			md = MODE_NEU;
		end

		if (!gate_running && md != MODE_NEU && md != settled_mode) begin
			// Entering a new mode opens the calculating gate.
			gate_running = 1'b1;
			gate_deadline = {1'b0, now} + END_W'(gate_ms_r);
			pct_seen_valid = 1'b0;
			settled_mode = md;
			if (md == MODE_CHG) begin
				est.to_full = '0;
				est.full_wait = 1'b1;
			end else begin
				est.left = '0;
				est.left_wait = 1'b1;
			end
		end else begin
			if (md == MODE_NEU) begin
				gate_running = 1'b0;
				gate_deadline = '0;
				settled_mode = MODE_NEU;
			end
			// A running gate reports calculating for the current mode.
			if (gate_running) begin
				if ({1'b0, now} < gate_deadline) begin
					held = 1'b1;
					if (md == MODE_CHG) begin
						est.to_full = '0;
						est.full_wait = 1'b1;
					end
					if (md == MODE_DIS) begin
						est.left = '0;
						est.left_wait = 1'b1;
					end
				end else begin
					gate_running = 1'b0;
					gate_deadline = '0;
				end
			end
			// Locked values move only when the integer percent changes.
			if (!held) begin
				if (md == MODE_CHG) begin
					if (!pct_seen_valid || pct != pct_seen) begin
						if (computed && est.to_full != 0) begin
							held_full = est.to_full;
						end
						pct_seen = pct;
						pct_seen_valid = 1'b1;
					end
					est.to_full = held_full;
				end else if (md == MODE_DIS) begin
					if (!pct_seen_valid || pct != pct_seen) begin
						if (computed && est.left != 0) begin
							held_left = est.left;
						end
						pct_seen = pct;
						pct_seen_valid = 1'b1;
					end
					est.left = held_left;
				end else begin
					pct_seen = pct;
					pct_seen_valid = 1'b1;
				end
			end
		end
		est.mode = md;
	endtask

	// Result words are checked first, then register writes and samples are taken in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ms_r = 16'd5000;
			min_rate_r = 16'd100;
			taper_r = 7'd80;
			full_pct_r = 7'd99;
			min_hours_r = 10'd51;
			max_full_r = 15'd10240;
			max_left_r = 15'd24576;
			pct_seen_valid = 1'b0;
			pct_seen = '0;
			settled_mode = MODE_NEU;
			held_full = '0;
			held_left = '0;
			gate_running = 1'b0;
			gate_deadline = '0;
			estimate_q.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_word.to_full = m_axis_tdata[HOURS_W-1:0];
				seen_word.left = m_axis_tdata[2*HOURS_W-1:HOURS_W];
				seen_word.full_wait = m_axis_tuser[0];
				seen_word.left_wait = m_axis_tuser[1];
				seen_word.mode = mode_t'(m_axis_tuser[3:2]);
				if (estimate_q.size() == 0) begin
					report_mismatch("result word with none outstanding, to_full_q10",
						32'(seen_word.to_full), 32'd0);
				end else begin
					want_word = estimate_q.pop_front();
					if (seen_word.to_full != want_word.to_full) begin
						report_mismatch("to_full_q10", 32'(seen_word.to_full),
							32'(want_word.to_full));
					end
					if (seen_word.full_wait != want_word.full_wait) begin
						report_mismatch("to_full_wait", 32'(seen_word.full_wait),
							32'(want_word.full_wait));
					end
					if (seen_word.left != want_word.left) begin
						report_mismatch("left_q10", 32'(seen_word.left), 32'(want_word.left));
					end
					if (seen_word.left_wait != want_word.left_wait) begin
						report_mismatch("left_wait", 32'(seen_word.left_wait),
							32'(want_word.left_wait));
					end
					if (seen_word.mode != want_word.mode) begin
						report_mismatch("mode_now", 32'(seen_word.mode), 32'(want_word.mode));
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GATE_MS: begin
						gate_ms_r = cfg_data[GATE_W-1:0];
					end
					CFG_MIN_RATE: begin
						min_rate_r = cfg_data[MINR_W-1:0];
					end
					CFG_TAPER: begin
						taper_r = cfg_data[PCT_W-1:0];
					end
					CFG_FULL_PCT: begin
						full_pct_r = cfg_data[PCT_W-1:0];
					end
					CFG_MIN_HOURS: begin
						min_hours_r = cfg_data[LO_W-1:0];
					end
					CFG_MAX_FULL: begin
						max_full_r = cfg_data[HOURS_W-1:0];
					end
					CFG_MAX_LEFT: begin
						max_left_r = cfg_data[HOURS_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				predict_estimate(s_axis_tdata[OFS_NOW +: TIME_W], s_axis_tuser[0],
					s_axis_tuser[1], s_axis_tdata[OFS_PCT +: PCT_W],
					s_axis_tdata[OFS_STORED +: MWH_W], s_axis_tdata[OFS_CAP +: MWH_W],
					s_axis_tdata[OFS_CHOSEN +: RATE_W], s_axis_tdata[OFS_GAUGE +: RATE_W],
					fresh_word);
				estimate_q.push_back(fresh_word);
			end
			pending = estimate_q.size();
		end
	end

endmodule

### dv/battery_eta_gate_and_lock_tb.sv
// Testbench top for battery_eta_gate_and_lock: clock, reset, sample and register stimulus
// with random idling on both streams, and the final verdict.
// Depends on betal_pkg, the block itself and eta_result_checker.
module battery_eta_gate_and_lock_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import betal_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     mismatches;
	int                     pending;

	// Both streams idle at random while this is set.
	logic                   idle_on = 1'b1;

	// Session state of the random samples.
	logic [TIME_W-1:0]      clock_ms = '0;
	int                     run_left = 0;
	int                     run_kind = 0;
	logic [PCT_W-1:0]       run_pct = '0;
	logic [MWH_W-1:0]       run_cap = '0;

	battery_eta_gate_and_lock u_dut (.*);

	eta_result_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sends one sample word after a random gap and waits until it is accepted.
	task automatic send_sample(input logic [TIME_W-1:0] now, input logic chg, input logic ac,
		input logic [PCT_W-1:0] pct, input logic [MWH_W-1:0] stored,
		input logic [MWH_W-1:0] cap, input logic [RATE_W-1:0] chosen,
		input logic [RATE_W-1:0] gauge);
		logic [IN_TDATA_W-1:0] word;
		int                    gap;
		word = '0;
		word[OFS_NOW +: TIME_W] = now;
		word[OFS_PCT +: PCT_W] = pct;
		word[OFS_STORED +: MWH_W] = stored;
		word[OFS_CAP +: MWH_W] = cap;
		word[OFS_CHOSEN +: RATE_W] = chosen;
		word[OFS_GAUGE +: RATE_W] = gauge;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = word;
		s_axis_tuser = {ac, chg};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Holds the sender until every outstanding result word has come back.
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] gate, input logic [15:0] min_rate,
		input logic [15:0] taper, input logic [15:0] full, input logic [15:0] min_hours,
		input logic [15:0] max_full, input logic [15:0] max_left);
		write_reg(CFG_GATE_MS, gate);
		write_reg(CFG_MIN_RATE, min_rate);
		write_reg(CFG_TAPER, taper);
		write_reg(CFG_FULL_PCT, full);
		write_reg(CFG_MIN_HOURS, min_hours);
		write_reg(CFG_MAX_FULL, max_full);
		write_reg(CFG_MAX_LEFT, max_left);
	endtask

	// Mostly runs of consistent discharging, charging or plugged-in samples with time
	// moving forward and the percent drifting; some runs are pure noise.
	task automatic random_samples(input int count);
		logic [TIME_W-1:0]  step;
		logic               chg;
		logic               ac;
		logic [PCT_W-1:0]   pct;
		logic [MWH_W-1:0]   stored;
		logic [RATE_W:0]    mag;
		logic [RATE_W-1:0]  chosen;
		logic [RATE_W-1:0]  gauge;
		int                 n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 149) == 0) begin
				idle_on = ~idle_on;
			end
			if (run_left == 0) begin
				run_kind = $urandom_range(0, 9);
				run_left = $urandom_range(3, 40);
				run_cap = ($urandom_range(0, 7) == 0) ? MWH_W'($urandom_range(0, 1048575))
					: MWH_W'($urandom_range(20000, 100000));
				run_pct = PCT_W'($urandom_range(0, 100));
			end
			run_left--;
			if (run_kind == 9) begin
				send_sample($urandom(), 1'($urandom()), 1'($urandom()),
					PCT_W'($urandom_range(0, 127)), MWH_W'($urandom()), MWH_W'($urandom()),
					RATE_W'($urandom()), RATE_W'($urandom()));
			end else begin
				step = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 70000)
					: $urandom_range(0, 2500);
				clock_ms = (clock_ms > ~step) ? '1 : clock_ms + step;
				// Percent rises while charging and falls while discharging.
				if ($urandom_range(0, 2) == 0) begin
					if (run_kind >= 4 && run_kind <= 7) begin
						if (run_pct < 100) run_pct++;
					end else if (run_kind <= 3) begin
						if (run_pct > 0) run_pct--;
					end
				end
				stored = MWH_W'((64'(run_cap) * run_pct) / 100);
				if ($urandom_range(0, 15) == 0) begin
					stored = MWH_W'($urandom_range(0, 1048575));
				end
				mag = ($urandom_range(0, 9) == 0) ? (RATE_W+1)'($urandom_range(0, 262144))
					: (RATE_W+1)'($urandom_range(20, 60000));
				chosen = (run_kind <= 3) ? RATE_W'(-mag) : RATE_W'(mag);
				gauge = chosen ^ RATE_W'($urandom_range(0, 63));
				// Near-zero selected rates fall back to the gauge rate.
				case ($urandom_range(0, 7))
					0: chosen = '0;
					1: chosen = RATE_W'(1);
					2: chosen = '1;
					default: begin
					end
				endcase
				if (run_kind <= 3) begin
					chg = 1'b0;
					ac = 1'b0;
				end else if (run_kind <= 7) begin
					chg = 1'b1;
					ac = 1'($urandom_range(0, 1));
				end else begin
					ac = 1'b1;
					chg = 1'($urandom_range(0, 1));
				end
				pct = run_pct;
				if ($urandom_range(0, 49) == 0) begin
					pct = PCT_W'($urandom_range(101, 127));
				end
				send_sample(clock_ms, chg, ac, pct, stored, run_cap, chosen, gauge);
			end
		end
	endtask

	initial begin
		int k;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed samples at the reset configuration.
		send_sample(0, 1'b0, 1'b1, 50, 50000, 100000, '0, '0);
		send_sample(500, 1'b0, 1'b1, 100, '1, '1, RATE_W'(262143), '0);
		send_sample(1000, 1'b0, 1'b0, 60, 60000, 100000, RATE_W'(-5000), '0);
		send_sample(3000, 1'b0, 1'b0, 60, 60000, 100000, RATE_W'(-262144), '0);
		send_sample(4000, 1'b1, 1'b1, 60, 60000, 100000, RATE_W'(3000), '0);
		send_sample(6001, 1'b1, 1'b1, 60, 60000, 100000, RATE_W'(1), RATE_W'(3000));
		send_sample(7000, 1'b1, 1'b1, 60, 61000, 100000, RATE_W'(9000), '0);
		send_sample(8000, 1'b1, 1'b1, 81, 81000, 100000, '1, RATE_W'(-4000));
		send_sample(9000, 1'b1, 1'b1, 85, 100000, 100000, RATE_W'(5000), '0);
		send_sample(10000, 1'b1, 1'b1, 99, 99000, 100000, RATE_W'(5000), '0);
		send_sample(11000, 1'b1, 1'b0, 127, 0, 100000, RATE_W'(5000), '0);
		send_sample(20000, 1'b1, 1'b0, 127, '1, '1, RATE_W'(262143), '0);
		send_sample(21000, 1'b1, 1'b0, 100, 0, '1, RATE_W'(100), '0);
		send_sample(22000, 1'b0, 1'b0, 100, '1, '1, RATE_W'(-100), '0);
		send_sample(40000, 1'b0, 1'b0, 99, 0, 100000, RATE_W'(-5000), '0);
		send_sample(41000, 1'b0, 1'b0, 98, 1000, 100000, RATE_W'(-99), RATE_W'(262143));
		send_sample(42000, 1'b0, 1'b0, 0, 1, 100000, RATE_W'(262143), '0);
		send_sample('1, 1'b0, 1'b0, 1, 50000, 100000, RATE_W'(-5000), RATE_W'(-262144));
		send_sample('1, 1'b0, 1'b1, 50, 50000, 100000, RATE_W'(-5000), '0);

		clock_ms = 100000;
		random_samples(200);
		drain_results();
		random_samples(200);
		drain_results();

		// Low extremes: no gate, any rate usable, no lower clamp.
		write_all(0, 0, 0, 0, 0, 32767, 32767);
		send_sample(100, 1'b1, 1'b0, 50, 10000, 100000, '0, '0);
		send_sample(100, 1'b1, 1'b0, 51, 10000, 100000, '0, '0);
		send_sample(200, 1'b1, 1'b0, 52, 100000, 100000, '0, '0);
		send_sample(300, 1'b0, 1'b0, 52, 50000, 100000, '0, '0);
		send_sample(301, 1'b0, 1'b0, 51, 50000, 100000, '0, '0);
		send_sample(302, 1'b1, 1'b1, 0, 0, 0, '0, '0);
		clock_ms = 1000;
		random_samples(300);
		drain_results();

		// High extremes, with the upper clamps below the lower one.
		write_all(65535, 65535, 100, 100, 1023, 0, 1000);
		clock_ms = 32'hFFF0_0000;
		random_samples(200);
		drain_results();

		for (k = 0; k < 3; k++) begin
			write_reg(CFG_GATE_MS, CFG_DATA_W'($urandom_range(0, 65535)));
			write_reg(CFG_MIN_RATE, ($urandom_range(0, 1) == 0)
				? CFG_DATA_W'($urandom_range(0, 2000))
				: CFG_DATA_W'($urandom_range(0, 65535)));
			write_reg(CFG_TAPER, CFG_DATA_W'($urandom_range(0, 100)));
			write_reg(CFG_FULL_PCT, CFG_DATA_W'($urandom_range(0, 100)));
			write_reg(CFG_MIN_HOURS, CFG_DATA_W'($urandom_range(0, 1023)));
			write_reg(CFG_MAX_FULL, CFG_DATA_W'($urandom_range(0, 32767)));
			write_reg(CFG_MAX_LEFT, CFG_DATA_W'($urandom_range(0, 32767)));
			clock_ms = $urandom_range(0, 32'h7FFF_FFFF);
			random_samples(300);
			drain_results();
		end

		write_all(3000, 50, 90, 95, 20, 20000, 30000);
		clock_ms = 5000;
		random_samples(250);
		drain_results();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: a random stall before each word, sometimes none.
	initial begin
		int stall;
		forever begin
			stall = idle_on ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Watchdog against a hung handshake.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### battery_eta_gate_and_lock.f
rtl/betal_pkg.sv
rtl/battery_eta_gate_and_lock.sv
dv/eta_result_checker.sv
dv/battery_eta_gate_and_lock_tb.sv
